@@ design/keyed_error_tracker_macros.svh @@
// Assertion macros for the keyed error tracker.
`ifndef KEYED_ERROR_TRACKER_MACROS_SVH
`define KEYED_ERROR_TRACKER_MACROS_SVH
`define KET_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error(msg);
`define KET_ASSERT_NXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error(msg);
`endif

@@ design/ket_pkg.sv @@
// Package: constants, tables and types of the keyed error tracker.
`timescale 1ns / 1ps
package ket_pkg;
   localparam int KEYS = 256;
   localparam int KW = $clog2(KEYS);
   localparam logic [16:0] ONE = 17'd65536;
   localparam logic [15:0] RATE_FLOOR = 16'd3277;
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_READ    = 1'b1;

   typedef struct packed {
      logic [31:0] cnt;
      logic [16:0] mean;
      logic [16:0] recent;
      logic [16:0] est;
   } entry_type;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_EXP  = 7'b0010000,
      S_CONF = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   function automatic logic [15:0] rate_lut(input logic [31:0] n);
      logic [15:0] r;
      if (n == 32'd0 || n > 32'd49) return RATE_FLOOR;
      unique case (n[5:0])
         6'd1: r = 22938;  6'd2: r = 16219;  6'd3: r = 13243;  6'd4: r = 11469;
         6'd5: r = 10258;  6'd6: r = 9364;   6'd7: r = 8670;   6'd8: r = 8110;
         6'd9: r = 7646;   6'd10: r = 7254;  6'd11: r = 6916;  6'd12: r = 6622;
         6'd13: r = 6362;  6'd14: r = 6130;  6'd15: r = 5922;  6'd16: r = 5734;
         6'd17: r = 5563;  6'd18: r = 5406;  6'd19: r = 5262;  6'd20: r = 5129;
         6'd21: r = 5005;  6'd22: r = 4890;  6'd23: r = 4783;  6'd24: r = 4682;
         6'd25: r = 4588;  6'd26: r = 4498;  6'd27: r = 4414;  6'd28: r = 4335;
         6'd29: r = 4259;  6'd30: r = 4188;  6'd31: r = 4120;  6'd32: r = 4055;
         6'd33: r = 3993;  6'd34: r = 3934;  6'd35: r = 3877;  6'd36: r = 3823;
         6'd37: r = 3771;  6'd38: r = 3721;  6'd39: r = 3673;  6'd40: r = 3627;
         6'd41: r = 3582;  6'd42: r = 3539;  6'd43: r = 3498;  6'd44: r = 3458;
         6'd45: r = 3419;  6'd46: r = 3382;  6'd47: r = 3346;  6'd48: r = 3311;
         default: r = 3277;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] frac_lut(input logic [2:0] k);
      logic [16:0] r;
      unique case (k)
         3'd0: r = 65536; 3'd1: r = 57835; 3'd2: r = 51039; 3'd3: r = 45042;
         3'd4: r = 39750; 3'd5: r = 35079; 3'd6: r = 30957; default: r = 27319;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] int_lut(input logic [3:0] m);
      logic [16:0] r;
      unique case (m)
         4'd0: r = 65536; 4'd1: r = 24109; 4'd2: r = 8869; 4'd3: r = 3263;
         4'd4: r = 1200;  4'd5: r = 442;   4'd6: r = 162;  4'd7: r = 60;
         4'd8: r = 22;    4'd9: r = 8;     4'd10: r = 3;   4'd11: r = 1;
         default: r = 0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] sat17(input logic [17:0] v);
      return (v > {1'b0, ONE}) ? ONE : v[16:0];
   endfunction
endpackage

@@ design/ket_divider.sv @@
// Iterative restoring divider: 17-bit dividend by 32-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`include "keyed_error_tracker_macros.svh"
module ket_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [16:0] quotient
);
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      cnt_in = cnt_ff; busy_in = busy_ff; q_in = q_ff; rem_in = rem_ff;
      dvs_in = dvs_ff; done_in = 1'b0;
      trial = {rem_ff[31:0], q_ff[16]};
      if (start) begin
         busy_in = 1'b1; cnt_in = 5'd0; q_in = dividend; rem_in = '0; dvs_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            q_in = {q_ff[15:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

   `KET_ASSERT_NXT(div_done_pulse, clock, reset, done_ff, !done_ff, "done longer than one cycle")
   `KET_ASSERT_IMP(div_cnt_range, clock, reset, busy_ff, cnt_ff <= 5'd16, "step count out of range")
   `KET_ASSERT_NXT(div_start_busy, clock, reset, start, busy_ff, "start did not set busy")
endmodule

@@ design/keyed_error_tracker.sv @@
// Top level: keyed error tracker with one entry memory and an iterative divider.
//   channel | dir | ports
//   req     | in  | req_valid req_stall req_func req_key req_predicted req_actual
//   rsp     | out | rsp_valid rsp_stall rsp_count rsp_mean_err rsp_recent_err ...
// An observe item passes through the 17-step divider for the mean.
// A read item takes the memory read, then the experience and confidence multiplies.
// After reset a clearing pass zeroes all KEYS entries of the memory; no item is taken then.
// One item at a time; the result register holds while rsp_stall is high.
`timescale 1ns / 1ps
`include "keyed_error_tracker_macros.svh"
module keyed_error_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_key,
   input  logic [16:0] req_predicted,
   input  logic [16:0] req_actual,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_count,
   output logic [16:0] rsp_mean_err,
   output logic [16:0] rsp_recent_err,
   output logic [16:0] rsp_estimate_out,
   output logic [16:0] rsp_confidence_out
);
   ket_pkg::entry_type mem [ket_pkg::KEYS];
   ket_pkg::entry_type rd_ff, ent_ff, ent_in;

   ket_pkg::state_type st_ff, st_in;
   logic              clr_ff;
   logic [ket_pkg::KW:0] clr_ptr_ff;
   logic [ket_pkg::KW-1:0] idx_ff, idx_in;
   logic              func_ff, func_in;
   logic [16:0]       act_ff, act_in, err_ff, err_in;
   logic [16:0]       exp_ff, exp_in, conf_ff, conf_in;
   logic              we;
   logic              rv_ff;
   logic              div_start, div_done;
   logic [16:0]       div_q, dmag;
   logic [31:0]       n_new;
   logic [15:0]       rate;
   logic [16:0]       p_s, a_s, rmag, emag, worst, acc;
   logic [32:0]       rprod, eprod, cprod, xprod;
   logic [16:0]       r_step, e_step;

   assign req_stall = clr_ff || (st_ff != ket_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (we) mem[clr_ff ? clr_ptr_ff[ket_pkg::KW-1:0] : idx_ff] <= clr_ff ? '0 : ent_in;
      rd_ff <= mem[idx_in];
   end

   always_comb begin
      p_s = ket_pkg::sat17({1'b0, req_predicted});
      a_s = ket_pkg::sat17({1'b0, req_actual});
      n_new = (rd_ff.cnt == 32'hFFFF_FFFF) ? rd_ff.cnt : rd_ff.cnt + 32'd1;
      rate = ket_pkg::rate_lut(n_new);
      rmag = (err_ff >= rd_ff.recent) ? err_ff - rd_ff.recent : rd_ff.recent - err_ff;
      emag = (act_ff >= rd_ff.est) ? act_ff - rd_ff.est : rd_ff.est - act_ff;
      dmag = (err_ff >= rd_ff.mean) ? err_ff - rd_ff.mean : rd_ff.mean - err_ff;
      rprod = rmag * rate;
      eprod = emag * rate;
      r_step = rprod[32:16];
      e_step = eprod[32:16];
      worst = (ent_ff.mean > ent_ff.recent) ? ent_ff.mean : ent_ff.recent;
      acc = ket_pkg::ONE - worst;
      xprod = ket_pkg::frac_lut(ent_ff.cnt[2:0]) * ket_pkg::int_lut(ent_ff.cnt[6:3]);
      cprod = acc * exp_ff;
   end

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; func_in = func_ff; act_in = act_ff; err_in = err_ff;
      ent_in = ent_ff; exp_in = exp_ff; conf_in = conf_ff; we = clr_ff; div_start = 1'b0;
      unique case (st_ff)
         ket_pkg::S_IDLE: begin
            if (req_valid && !req_stall) begin
               idx_in = req_key[ket_pkg::KW-1:0];
               func_in = req_func;
               act_in = a_s;
               err_in = (a_s >= p_s) ? a_s - p_s : p_s - a_s;
               st_in = ket_pkg::S_READ;
            end
         end
         ket_pkg::S_READ: begin
            ent_in = rd_ff;
            if (func_ff == ket_pkg::FUNC_READ) st_in = ket_pkg::S_EXP;
            else begin
               div_start = 1'b1;
               st_in = ket_pkg::S_DIV;
            end
         end
         ket_pkg::S_DIV: begin
            if (div_done) begin
               ent_in.cnt = n_new;
               ent_in.mean = (err_ff >= rd_ff.mean)
                  ? ket_pkg::sat17({1'b0, rd_ff.mean} + {1'b0, div_q})
                  : ((div_q > rd_ff.mean) ? 17'd0 : rd_ff.mean - div_q);
               st_in = ket_pkg::S_MUL;
            end
         end
         ket_pkg::S_MUL: begin
            ent_in.recent = (err_ff >= rd_ff.recent)
               ? ket_pkg::sat17({1'b0, rd_ff.recent} + {1'b0, r_step})
               : ((r_step > rd_ff.recent) ? 17'd0 : rd_ff.recent - r_step);
            ent_in.est = (act_ff >= rd_ff.est)
               ? ket_pkg::sat17({1'b0, rd_ff.est} + {1'b0, e_step})
               : ((e_step > rd_ff.est) ? 17'd0 : rd_ff.est - e_step);
            we = 1'b1;
            st_in = ket_pkg::S_EXP;
         end
         ket_pkg::S_EXP: begin
            if (ent_ff.cnt >= 32'd96) exp_in = ket_pkg::ONE;
            else exp_in = ket_pkg::ONE - 17'((xprod + 33'd32768) >> 16);
            st_in = ket_pkg::S_CONF;
         end
         ket_pkg::S_CONF: begin
            conf_in = (ent_ff.cnt == 32'd0) ? 17'd0
                      : ket_pkg::sat17(18'((cprod + 33'd32768) >> 16));
            st_in = ket_pkg::S_OUT;
         end
         ket_pkg::S_OUT: begin
            if (!rsp_stall) st_in = ket_pkg::S_IDLE;
         end
         default: st_in = ket_pkg::S_IDLE;
      endcase
   end

   ket_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dmag),
      .divisor(n_new), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ket_pkg::S_IDLE; clr_ff <= 1'b1; clr_ptr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= (st_in == ket_pkg::S_OUT);
         if (clr_ff) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == (ket_pkg::KW+1)'(ket_pkg::KEYS - 1)) clr_ff <= 1'b0;
         end
      end
      idx_ff <= idx_in; func_ff <= func_in; act_ff <= act_in; err_ff <= err_in;
      ent_ff <= ent_in; exp_ff <= exp_in; conf_ff <= conf_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_count = ent_ff.cnt;
   assign rsp_mean_err = ent_ff.mean;
   assign rsp_recent_err = ent_ff.recent;
   assign rsp_estimate_out = ent_ff.est;
   assign rsp_confidence_out = conf_ff;

   `KET_ASSERT_IMP(top_no_req_in_clear, clock, reset, clr_ff, req_stall, "item taken while clearing")
   `KET_ASSERT_IMP(top_valid_in_out, clock, reset, rsp_valid, st_ff == ket_pkg::S_OUT, "valid outside output state")
   `KET_ASSERT_IMP(top_no_write_on_read, clock, reset, !clr_ff && we, func_ff == ket_pkg::FUNC_OBSERVE, "write on read item")
endmodule

@@ bench/keyed_error_tracker_tb.sv @@
// Testbench: random and directed items against a per-key error tracker predictor.
`timescale 1ns / 1ps
module keyed_error_tracker_tb;
   typedef struct packed {
      logic        func;
      logic [7:0]  key;
      logic [16:0] predicted;
      logic [16:0] actual;
   } req_item_type;

   typedef struct packed {
      logic [31:0] count;
      logic [16:0] mean_err;
      logic [16:0] recent_err;
      logic [16:0] estimate;
      logic [16:0] confidence;
   } rsp_item_type;

   localparam int   CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [7:0]  req_key = '0;
   logic [16:0] req_predicted = '0;
   logic [16:0] req_actual = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_count;
   logic [16:0] rsp_mean_err, rsp_recent_err, rsp_estimate_out, rsp_confidence_out;

   keyed_error_tracker dut (.*);

   req_item_type pending_items[$];
   rsp_item_type expected_rsps[$];
   int        mismatches = 0;
   int        cycles = 0;
   bit        stim_done = 1'b0;
   bit        hold_off = 1'b0;
   int        burst_left = 0;
   int        gap_left = 0;

   logic [31:0] trk_count[ket_pkg::KEYS];
   logic [16:0] trk_mean[ket_pkg::KEYS], trk_recent[ket_pkg::KEYS], trk_est[ket_pkg::KEYS];

   int unsigned rate_tab[49] = '{
      22938, 16219, 13243, 11469, 10258, 9364, 8670, 8110, 7646, 7254,
      6916, 6622, 6362, 6130, 5922, 5734, 5563, 5406, 5262, 5129,
      5005, 4890, 4783, 4682, 4588, 4498, 4414, 4335, 4259, 4188,
      4120, 4055, 3993, 3934, 3877, 3823, 3771, 3721, 3673, 3627,
      3582, 3539, 3498, 3458, 3419, 3382, 3346, 3311, 3277};
   longint unsigned frac_tab[8] = '{65536, 57835, 51039, 45042, 39750, 35079, 30957, 27319};
   longint unsigned int_tab[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};

   function automatic longint unsigned clamp_one(longint unsigned v);
      return (v > 65536) ? 65536 : v;
   endfunction

   function automatic longint unsigned step_toward(longint unsigned cur, longint unsigned tgt,
                                                   longint unsigned rate, bit by_div,
                                                   longint unsigned n);
      longint unsigned mag, stp;
      mag = (tgt >= cur) ? tgt - cur : cur - tgt;
      stp = by_div ? mag / n : (mag * rate) >> 16;
      if (tgt >= cur) return clamp_one(cur + stp);
      return (stp > cur) ? 0 : cur - stp;
   endfunction

   function automatic longint unsigned trust_level(longint unsigned n, longint unsigned mean,
                                                   longint unsigned recent);
      longint unsigned worst, e, expv;
      if (n == 0) return 0;
      worst = clamp_one((mean > recent) ? mean : recent);
      if ((n >> 3) >= 12) expv = 65536;
      else begin
         e = clamp_one((frac_tab[n & 7] * int_tab[n >> 3] + 32768) >> 16);
         expv = 65536 - e;
      end
      return clamp_one(((65536 - worst) * expv + 32768) >> 16);
   endfunction

   function automatic rsp_item_type track_item(req_item_type it);
      rsp_item_type r;
      int idx;
      longint unsigned p, a, err, n, rate;
      idx = it.key % ket_pkg::KEYS;
      if (it.func == ket_pkg::FUNC_OBSERVE) begin
         p = clamp_one(it.predicted);
         a = clamp_one(it.actual);
         err = (a >= p) ? a - p : p - a;
         n = trk_count[idx];
         if (n != 64'hFFFF_FFFF) n++;
         trk_count[idx] = 32'(n);
         rate = (n >= 1 && n <= 49) ? rate_tab[n - 1] : 3277;
         trk_mean[idx] = 17'(step_toward(trk_mean[idx], err, 0, 1'b1, n));
         trk_recent[idx] = 17'(step_toward(trk_recent[idx], err, rate, 1'b0, n));
         trk_est[idx] = 17'(step_toward(trk_est[idx], a, rate, 1'b0, n));
      end
      r.count = trk_count[idx];
      r.mean_err = trk_mean[idx];
      r.recent_err = trk_recent[idx];
      r.estimate = trk_est[idx];
      r.confidence = 17'(trust_level(trk_count[idx], trk_mean[idx], trk_recent[idx]));
      return r;
   endfunction

   function automatic logic [16:0] rand_q16();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic push_item(logic f, logic [7:0] k, logic [16:0] p, logic [16:0] a);
      req_item_type it;
      it.func = f; it.key = k; it.predicted = p; it.actual = a;
      pending_items.push_back(it);
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      int i;
      logic [7:0] k;
      for (i = 0; i < ket_pkg::KEYS; i++) begin
         trk_count[i] = 0; trk_mean[i] = 0; trk_recent[i] = 0; trk_est[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      push_item(ket_pkg::FUNC_READ, 8'd7, 17'h1FFFF, 17'h1FFFF);
      push_item(ket_pkg::FUNC_OBSERVE, 8'd0, 17'd0, 17'd0);
      push_item(ket_pkg::FUNC_OBSERVE, 8'd255, 17'd0, 17'd65536);
      push_item(ket_pkg::FUNC_OBSERVE, 8'd255, 17'h1FFFF, 17'd0);
      push_item(ket_pkg::FUNC_OBSERVE, 8'd255, 17'd65536, 17'h1FFFF);
      push_item(ket_pkg::FUNC_READ, 8'd255, 17'd0, 17'd0);
      push_item(ket_pkg::FUNC_OBSERVE, 8'd1, 17'h15555, 17'h0AAAA);
      push_item(ket_pkg::FUNC_OBSERVE, 8'd1, 17'h0AAAA, 17'h15555);
      push_item(ket_pkg::FUNC_READ, 8'd0, 17'd1234, 17'd4321);
      for (i = 0; i < 14; i++) push_item(ket_pkg::FUNC_OBSERVE, 8'd2, rand_q16(), rand_q16());
      for (i = 0; i < 40; i++) push_item(ket_pkg::FUNC_OBSERVE, 8'd3, rand_q16(), 17'd30000);
      for (i = 0; i < 560; i++) begin
         k = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(2, 9));
         push_item(($urandom_range(0, 4) == 0) ? ket_pkg::FUNC_READ : ket_pkg::FUNC_OBSERVE,
                   k, rand_q16(), rand_q16());
         if (i == 280) begin
            wait (pending_items.size() == 0 && !req_valid && expected_rsps.size() == 0);
            hold_off = 1'b1;
            repeat (10) @(posedge clock);
            hold_off = 1'b0;
         end
      end
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_rsps.push_back(track_item({req_func, req_key, req_predicted, req_actual}));
         end
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_off) begin
            {req_func, req_key, req_predicted, req_actual} <= pending_items.pop_front();
            req_valid <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_count, rsp_mean_err, rsp_recent_err, rsp_estimate_out,
                   rsp_confidence_out};
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         rsp_stall <= ((cycles / 64) % 3 == 2) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      int tail;
      tail = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (stim_done && pending_items.size() == 0 && !req_valid
             && expected_rsps.size() == 0) tail++;
         else tail = 0;
         if (tail == 100) begin
            if (mismatches == 0) $display("RESULT: OK");
            else $display("RESULT: ERROR");
            $finish;
         end
      end
   end
endmodule

@@ files.f @@
+incdir+design
design/ket_pkg.sv
design/ket_divider.sv
design/keyed_error_tracker.sv
bench/keyed_error_tracker_tb.sv
